[design/spq_pkg.sv]
// Package for the stable priority queue core: status and command codes,
// default sizes, and the controller-to-datapath command struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

    localparam int DEF_CAPACITY      = 16;
    localparam int DEF_PRIORITY_BITS = 16;
    localparam int DEF_TAG_BITS      = 32;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    localparam logic [1:0] STATUS_INSERTED = 2'd0;
    localparam logic [1:0] STATUS_REMOVED  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY    = 2'd2;
    localparam logic [1:0] STATUS_FULL     = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;  // capture the request fields
        logic exec;  // apply the captured request to the sorted chain
    } t_spq_ctrl;

endpackage
`default_nettype wire

[design/spq_ctrl.sv]
// Controller for the stable priority queue core: request handshake and
// sequencing of the datapath. Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    output spq_pkg::t_spq_ctrl     o_ctrl
);
    import spq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    assign busy        = (r_state != S_IDLE);
    assign o_ctrl.load = start && (r_state == S_IDLE);
    assign o_ctrl.exec = (r_state == S_EXEC);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

[design/spq_datapath.sv]
// Datapath for the stable priority queue core: the sorted slot chain, the
// entry count and the result registers. Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spq_datapath #(
    parameter int CAPACITY      = spq_pkg::DEF_CAPACITY,
    parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS,
    parameter int TAG_BITS      = spq_pkg::DEF_TAG_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire spq_pkg::t_spq_ctrl              i_ctrl,
    input  wire logic                            i_cmd,
    input  wire logic signed [PRIORITY_BITS-1:0] i_entry_priority,
    input  wire logic [TAG_BITS-1:0]             i_entry_tag,
    output logic                                 o_valid,
    output logic [1:0]                           o_status,
    output logic signed [PRIORITY_BITS-1:0]      o_head_priority,
    output logic [TAG_BITS-1:0]                  o_head_tag,
    output logic [$clog2(CAPACITY+1)-1:0]        o_occupancy
);
    import spq_pkg::*;

    localparam int CntW = $clog2(CAPACITY + 1);

    // Captured request
    logic                            r_cmd;
    logic signed [PRIORITY_BITS-1:0] r_prio;
    logic [TAG_BITS-1:0]             r_tag;

    // Sorted chain, head in slot 0
    logic signed [PRIORITY_BITS-1:0] r_slot_prio [CAPACITY];
    logic [TAG_BITS-1:0]             r_slot_tag  [CAPACITY];
    logic signed [PRIORITY_BITS-1:0] n_slot_prio [CAPACITY];
    logic [TAG_BITS-1:0]             n_slot_tag  [CAPACITY];
    logic [CntW-1:0]                 r_count;
    logic [CntW-1:0]                 n_count;

    // Slot holds an entry that stays ahead of the new one
    logic [CAPACITY-1:0] keep_ahead;

    logic is_full;
    logic is_empty;
    logic do_insert;
    logic do_remove;

    logic                            r_valid;
    logic [1:0]                      r_status;
    logic signed [PRIORITY_BITS-1:0] r_head_prio;
    logic [TAG_BITS-1:0]             r_head_tag;
    logic [1:0]                      n_status;

    assign is_full   = (r_count == CntW'(CAPACITY));
    assign is_empty  = (r_count == '0);
    assign do_insert = (r_cmd == CMD_ENQUEUE) && !is_full;
    assign do_remove = (r_cmd == CMD_DEQUEUE) && !is_empty;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_slot
            logic ahead_prev;
            assign keep_ahead[g] = (CntW'(g) < r_count) && (r_slot_prio[g] <= r_prio);

            if (g == 0) begin : g_first
                assign ahead_prev = 1'b1;
            end else begin : g_rest
                assign ahead_prev = keep_ahead[g-1];
            end

            always_comb begin
                n_slot_prio[g] = r_slot_prio[g];
                n_slot_tag[g]  = r_slot_tag[g];
                if (do_insert) begin
                    if (keep_ahead[g]) begin
                        n_slot_prio[g] = r_slot_prio[g];
                        n_slot_tag[g]  = r_slot_tag[g];
                    end else if (ahead_prev) begin
                        n_slot_prio[g] = r_prio;
                        n_slot_tag[g]  = r_tag;
                    end else if (g > 0) begin
                        // shift one slot toward the tail
                        n_slot_prio[g] = r_slot_prio[(g > 0) ? g - 1 : 0];
                        n_slot_tag[g]  = r_slot_tag[(g > 0) ? g - 1 : 0];
                    end
                end else if (do_remove && (g < CAPACITY - 1)) begin
                    // advance toward the head
                    n_slot_prio[g] = r_slot_prio[(g < CAPACITY - 1) ? g + 1 : g];
                    n_slot_tag[g]  = r_slot_tag[(g < CAPACITY - 1) ? g + 1 : g];
                end
            end
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        n_status = STATUS_INSERTED;
        if (r_cmd == CMD_ENQUEUE) begin
            if (is_full) begin
                n_status = STATUS_FULL;
            end else begin
                n_status = STATUS_INSERTED;
                n_count  = r_count + CntW'(1);
            end
        end else begin
            if (is_empty) begin
                n_status = STATUS_EMPTY;
            end else begin
                n_status = STATUS_REMOVED;
                n_count  = r_count - CntW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd  <= i_cmd;
            r_prio <= i_entry_priority;
            r_tag  <= i_entry_tag;
        end
        if (i_ctrl.exec) begin
            r_slot_prio <= n_slot_prio;
            r_slot_tag  <= n_slot_tag;
            r_status    <= n_status;
            r_head_prio <= do_remove ? r_slot_prio[0] : '0;
            r_head_tag  <= do_remove ? r_slot_tag[0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctrl.exec;
            if (i_ctrl.exec) begin
                r_count <= n_count;
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_head_priority = r_head_prio;
    assign o_head_tag      = r_head_tag;
    assign o_occupancy     = r_count;

endmodule
`default_nettype wire

[design/stable_priority_queue_core.sv]
// Top level of the stable priority queue core: a sorted shifting register chain
// with FIFO order among equal priorities. Depends on spq_pkg, spq_ctrl, spq_datapath.
//
//   Channel   Handshake          Fields
//   request   start / busy       i_cmd, i_entry_priority, i_entry_tag
//   result    o_valid (strobe)   o_status, o_head_priority, o_head_tag, o_occupancy
//
// A request is taken when start is high and busy is low; busy then stays high
// for one cycle while the chain shifts in a single step, and the result strobe
// follows in the next cycle, when busy is already low. No new request is
// taken during the chain update. Synchronous reset empties the queue; slot
// contents are not cleared. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module stable_priority_queue_core #(
    parameter int CAPACITY      = spq_pkg::DEF_CAPACITY,
    parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS,
    parameter int TAG_BITS      = spq_pkg::DEF_TAG_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            i_cmd,
    input  wire logic signed [PRIORITY_BITS-1:0] i_entry_priority,
    input  wire logic [TAG_BITS-1:0]             i_entry_tag,
    output logic                                 o_valid,
    output logic [1:0]                           o_status,
    output logic signed [PRIORITY_BITS-1:0]      o_head_priority,
    output logic [TAG_BITS-1:0]                  o_head_tag,
    output logic [$clog2(CAPACITY+1)-1:0]        o_occupancy
);
    import spq_pkg::*;

    t_spq_ctrl ctrl;

    spq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_ctrl  (ctrl)
    );

    spq_datapath #(
        .CAPACITY      (CAPACITY),
        .PRIORITY_BITS (PRIORITY_BITS),
        .TAG_BITS      (TAG_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (ctrl),
        .i_cmd            (i_cmd),
        .i_entry_priority (i_entry_priority),
        .i_entry_tag      (i_entry_tag),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_head_priority  (o_head_priority),
        .o_head_tag       (o_head_tag),
        .o_occupancy      (o_occupancy)
    );

endmodule
`default_nettype wire
